### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int MATCH_SAT    = 31;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int IDX_W        = $clog2(CAPACITY + 1);
  localparam int N_W          = $clog2(MAX_RESULTS + 1);
  localparam int THR_W        = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd3;

  // configuration port
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam logic [0:0] REG_LONG_THRESHOLD = 1'b0;

  // operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_LIST    = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] entry_id;
    logic [7:0]  entry_hours;
    logic        entry_channel;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_id;
    logic [7:0]  out_hours;
    logic        out_channel;
    logic        entry_valid;
    logic [1:0]  status;
    logic [4:0]  match_count;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  hours;
    logic        channel;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_STEP,
    S_INS_CMP,
    S_EXT_RD0,
    S_EXT_FRONT,
    S_EXT_STEP,
    S_EXT_MOVE,
    S_CNT_STEP,
    S_CNT_CHK,
    S_LST_STEP,
    S_LST_CHK,
    S_RSP_PLAIN,
    S_RSP_FULL,
    S_RSP_EMPTY,
    S_RSP_FRONT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_OCC,
    IDX_CLR,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_FULL,
    KIND_EMPTY,
    KIND_FRONT,
    KIND_LIST
  } out_kind_t;

  typedef struct packed {
    logic      cap_in;
    idx_op_t   idx_op;
    logic      rd_en;
    logic      rd_at_prev;
    logic      wr_en;
    logic      wr_at_prev;
    logic      wr_src_new;
    logic      occ_inc;
    logic      occ_dec;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      n_clr;
    logic      n_inc;
    logic      front_cap;
    logic      out_load;
    out_kind_t out_kind;
  } spq_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_zero;
    logic       idx_eq_occ;
    logic       occ_zero;
    logic       occ_full;
    logic       cnt_zero;
    logic       n_eq_total;
    logic       rd_ge;
    logic       rd_match;
    logic       out_free;
  } spq_stat_t;

endpackage

### hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for insert, extract and list walks over the entry memory.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        priority case (stat.op)
          OP_INSERT:  state_nxt = stat.occ_full ? S_RSP_FULL : S_INS_STEP;
          OP_EXTRACT: state_nxt = stat.occ_zero ? S_RSP_EMPTY : S_EXT_RD0;
          OP_LIST:    state_nxt = S_CNT_STEP;
          default:    state_nxt = S_RSP_PLAIN;
        endcase
      end
      S_INS_STEP:  state_nxt = stat.idx_zero ? S_RSP_PLAIN : S_INS_CMP;
      S_INS_CMP:   state_nxt = stat.rd_ge ? S_RSP_PLAIN : S_INS_STEP;
      S_EXT_RD0:   state_nxt = S_EXT_FRONT;
      S_EXT_FRONT: state_nxt = S_EXT_STEP;
      S_EXT_STEP:  state_nxt = stat.idx_eq_occ ? S_RSP_FRONT : S_EXT_MOVE;
      S_EXT_MOVE:  state_nxt = S_EXT_STEP;
      S_CNT_STEP: begin
        if (stat.idx_eq_occ) begin
          state_nxt = stat.cnt_zero ? S_RSP_PLAIN : S_LST_STEP;
        end else begin
          state_nxt = S_CNT_CHK;
        end
      end
      S_CNT_CHK:   state_nxt = S_CNT_STEP;
      S_LST_STEP: begin
        state_nxt = (stat.n_eq_total || stat.idx_eq_occ) ? S_IDLE : S_LST_CHK;
      end
      S_LST_CHK: begin
        if (!stat.rd_match || stat.out_free) state_nxt = S_LST_STEP;
      end
      S_RSP_PLAIN, S_RSP_FULL, S_RSP_EMPTY, S_RSP_FRONT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.out_kind = KIND_PLAIN;
    in_stall     = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.cap_in = in_valid;
      end
      S_DECODE: begin
        priority case (stat.op)
          OP_INSERT:  cmd.idx_op = IDX_LOAD_OCC;
          OP_EXTRACT: cmd.idx_op = IDX_CLR;
          OP_LIST: begin
            cmd.idx_op  = IDX_CLR;
            cmd.cnt_clr = 1'b1;
          end
          default: cmd.idx_op = IDX_HOLD;
        endcase
      end
      S_INS_STEP: begin
        if (stat.idx_zero) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_src_new = 1'b1;
          cmd.occ_inc    = 1'b1;
        end else begin
          cmd.rd_en      = 1'b1;
          cmd.rd_at_prev = 1'b1;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.rd_ge) begin
          cmd.wr_src_new = 1'b1;
          cmd.occ_inc    = 1'b1;
        end else begin
          cmd.idx_op = IDX_DEC;
        end
      end
      S_EXT_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.idx_op = IDX_INC;
      end
      S_EXT_FRONT: begin
        cmd.front_cap = 1'b1;
      end
      S_EXT_STEP: begin
        if (stat.idx_eq_occ) begin
          cmd.occ_dec = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_EXT_MOVE: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_at_prev = 1'b1;
        cmd.idx_op     = IDX_INC;
      end
      S_CNT_STEP: begin
        if (stat.idx_eq_occ) begin
          cmd.idx_op = IDX_CLR;
          cmd.n_clr  = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_CNT_CHK: begin
        cmd.cnt_inc = stat.rd_match;
        cmd.idx_op  = IDX_INC;
      end
      S_LST_STEP: begin
        cmd.rd_en = !(stat.n_eq_total || stat.idx_eq_occ);
      end
      S_LST_CHK: begin
        cmd.out_kind = KIND_LIST;
        if (!stat.rd_match) begin
          cmd.idx_op = IDX_INC;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.n_inc    = 1'b1;
          cmd.idx_op   = IDX_INC;
        end
      end
      S_RSP_PLAIN: begin
        cmd.out_kind = KIND_PLAIN;
        cmd.out_load = stat.out_free;
      end
      S_RSP_FULL: begin
        cmd.out_kind = KIND_FULL;
        cmd.out_load = stat.out_free;
      end
      S_RSP_EMPTY: begin
        cmd.out_kind = KIND_EMPTY;
        cmd.out_load = stat.out_free;
      end
      S_RSP_FRONT: begin
        cmd.out_kind = KIND_FRONT;
        cmd.out_load = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### hdl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Entry memory, walk index, occupancy, match counters and result register.
// ----------------------------------------------------------------------------
module spq_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  spq_pkg::in_word_t              in_word,
  input  logic [spq_pkg::THR_W-1:0]      thr,
  input  spq_pkg::spq_cmd_t              cmd,
  output spq_pkg::spq_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spq_pkg::out_word_t             out_word
);
  import spq_pkg::*;

  in_word_t          req_r;
  entry_t            new_entry;
  entry_t            mem [CAPACITY];
  entry_t            rd_q_r;
  entry_t            front_r;
  entry_t            wr_data;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  idx_prev;
  logic [IDX_W-1:0]  occ_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [N_W-1:0]    n_r;
  logic [N_W-1:0]    total;
  logic              n_last;
  logic [4:0]        match_cnt;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              out_valid_r;
  out_word_t         out_word_r, out_nxt;

  assign new_entry = '{id: req_r.entry_id, hours: req_r.entry_hours,
                       channel: req_r.entry_channel};
  assign idx_prev  = idx_r - IDX_W'(1);
  assign rd_addr   = cmd.rd_at_prev ? idx_prev[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  assign wr_addr   = cmd.wr_at_prev ? idx_prev[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  assign wr_data   = cmd.wr_src_new ? new_entry : rd_q_r;

  // list bookkeeping
  assign total     = (int'(cnt_r) > MAX_RESULTS) ? N_W'(MAX_RESULTS) : N_W'(cnt_r);
  assign n_last    = (N_W'(n_r + N_W'(1)) == total);
  assign match_cnt = (int'(cnt_r) > MATCH_SAT) ? 5'(MATCH_SAT) : 5'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.cap_in) req_r <= in_word;
    if (cmd.front_cap) front_r <= rd_q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    unique case (cmd.idx_op)
      IDX_HOLD:     idx_nxt = idx_r;
      IDX_LOAD_OCC: idx_nxt = occ_r;
      IDX_CLR:      idx_nxt = '0;
      IDX_INC:      idx_nxt = idx_r + IDX_W'(1);
      IDX_DEC:      idx_nxt = idx_prev;
      default:      idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      occ_r <= '0;
      cnt_r <= '0;
      n_r   <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.occ_inc) begin
        occ_r <= occ_r + IDX_W'(1);
      end else if (cmd.occ_dec) begin
        occ_r <= occ_r - IDX_W'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.n_clr) begin
        n_r <= '0;
      end else if (cmd.n_inc) begin
        n_r <= n_r + N_W'(1);
      end
    end
  end

  // result word
  always_comb begin
    out_nxt      = '0;
    out_nxt.last = 1'b1;
    unique case (cmd.out_kind)
      KIND_PLAIN: out_nxt.status = ST_OK;
      KIND_FULL:  out_nxt.status = ST_FULL;
      KIND_EMPTY: out_nxt.status = ST_EMPTY;
      KIND_FRONT: begin
        out_nxt.out_id      = front_r.id;
        out_nxt.out_hours   = front_r.hours;
        out_nxt.out_channel = front_r.channel;
        out_nxt.entry_valid = 1'b1;
      end
      KIND_LIST: begin
        out_nxt.out_id      = rd_q_r.id;
        out_nxt.out_hours   = rd_q_r.hours;
        out_nxt.out_channel = rd_q_r.channel;
        out_nxt.entry_valid = 1'b1;
        out_nxt.match_count = match_cnt;
        out_nxt.last        = n_last;
      end
      default: out_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_word_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    stat            = '0;
    stat.op         = req_r.op;
    stat.idx_zero   = (idx_r == '0);
    stat.idx_eq_occ = (idx_r == occ_r);
    stat.occ_zero   = (occ_r == '0);
    stat.occ_full   = (int'(occ_r) >= CAPACITY);
    stat.cnt_zero   = (cnt_r == '0);
    stat.n_eq_total = (n_r == total);
    stat.rd_ge      = (rd_q_r.hours >= req_r.entry_hours);
    stat.rd_match   = (rd_q_r.hours > thr);
    stat.out_free   = !out_valid_r || !out_stall;
  end

endmodule

### hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by descending hours, FIFO among equals.
// ----------------------------------------------------------------------------
// Usage:
//  - in_word (op, entry_id, entry_hours, entry_channel) is taken when in_valid
//    is high and in_stall low. One request is worked at a time; in_stall is
//    low only while the sequencer sits idle.
//  - Each request yields one or more out_word results on out_valid/out_stall.
//    A list request gives one word per entry with hours above long_threshold,
//    front first, with last set on the final word.
//  - n = stored entries. Insert walks up from the tail, stopping at the
//    front or after passing the k tail entries of lower hours; extract
//    takes the front and shifts the rest forward; list counts matches over
//    all n, then walks to emit them, or answers at once if none match. Full,
//    empty and unknown answer directly. Each entry visited takes a
//    registered read and a compare or move step. Idle takes new requests.
//  - The result sits in an output register, so the next request is accepted
//    while a final word still waits; a stall on out holds the sequencer when
//    it has a new word to load while the previous one still waits.
//  - long_threshold lives on the APB-style cfg_ port at byte address 0.
//  - Synchronous reset empties the queue and sets long_threshold to 3. The
//    entry memory itself is not cleared; only slots below occupancy are read.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spq_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output spq_pkg::out_word_t           out_word,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [spq_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [spq_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [spq_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import spq_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             cfg_wr;
  logic             cfg_hit;
  spq_cmd_t         cmd;
  spq_stat_t        stat;

  // register index is paddr[2]; low byte-lane bits are ignored
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_LONG_THRESHOLD);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? CFG_DW'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr && cfg_hit) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end

  // sequencer
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  spq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .thr       (thr_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### test/tb_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A shadow copy of the
// queue predicts every result word. The run starts with a table of directed
// requests, then goes through random phases with different thresholds, sender
// gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  import spq_pkg::*;

  // op value 3 has no function; the block must answer it with a bare last word
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [CFG_AW-1:0] THR_ADDR   = CFG_AW'(4 * int'(REG_LONG_THRESHOLD));
  localparam logic [CFG_AW-1:0] SPARE_ADDR = CFG_AW'(4);  // no register here

  localparam int SETTLE      = 2 * CAPACITY + 8;
  localparam int HOLD_LEN    = 400;
  localparam int LIMIT       = 400000;
  localparam int PHASE_WORDS = 35;
  localparam int N_PHASES    = 6;

  typedef struct {
    in_word_t  w;
    bit        fixed;   // res holds the typed-in answer
    out_word_t res;
  } row_t;

  typedef struct {
    int thr;            // -1: random threshold
    int idle_pct;
    int stall_pct;
    bit press;
    int ins_pct;
  } phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]    cfg_paddr = '0;
  logic [CFG_DW-1:0]    cfg_pwdata = '0;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  // shadow of the block: sorted entries, threshold, and the words still due
  entry_t               shadow_queue[$];
  logic [THR_W-1:0]     shadow_thr = THR_RESET;
  out_word_t            due_words[$];

  row_t                 plan[$];
  phase_t               phases[N_PHASES];

  // traffic knobs, written by the main process only
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  bit                   pressure_req = 1'b0;

  // receiver-side hold-off bookkeeping, owned by the receiver process
  int                   hold_cnt = 0;
  bit                   hold_done = 1'b0;

  int                   mismatches = 0;
  int                   cycle_count = 0;

  sorted_priority_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("tb_sorted_priority_queue failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // word builders
  // --------------------------------------------------------------------------

  // answer with no entry: insert ok/full, empty extract, empty list, op 3
  function automatic out_word_t status_word(logic [1:0] st);
    out_word_t w;
    w = '0;
    w.status = st;
    w.last = 1'b1;
    return w;
  endfunction

  function automatic out_word_t entry_word(entry_t e, logic [4:0] cnt, logic lst);
    out_word_t w;
    w = '0;
    w.out_id = e.id;
    w.out_hours = e.hours;
    w.out_channel = e.channel;
    w.entry_valid = 1'b1;
    w.status = ST_OK;
    w.match_count = cnt;
    w.last = lst;
    return w;
  endfunction

  function automatic string show(out_word_t w);
    return $sformatf("id=%h hours=%h ch=%b valid=%b status=%0d count=%0d last=%b",
                     w.out_id, w.out_hours, w.out_channel, w.entry_valid,
                     w.status, w.match_count, w.last);
  endfunction

  // --------------------------------------------------------------------------
  // shadow queue: applies one accepted request and queues the words it owes
  // --------------------------------------------------------------------------
  function automatic void apply_queue_op(in_word_t w);
    entry_t e;
    int     pos;
    int     hits;
    int     lim;
    int     emitted;
    e = '{id: w.entry_id, hours: w.entry_hours, channel: w.entry_channel};
    case (w.op)
      OP_INSERT: begin
        if (shadow_queue.size() >= CAPACITY) begin
          due_words.push_back(status_word(ST_FULL));
        end else begin
          // new entry goes behind everything of equal or higher hours
          pos = 0;
          while (pos < shadow_queue.size() && shadow_queue[pos].hours >= e.hours)
            pos++;
          shadow_queue.insert(pos, e);
          due_words.push_back(status_word(ST_OK));
        end
      end
      OP_EXTRACT: begin
        if (shadow_queue.size() == 0) begin
          due_words.push_back(status_word(ST_EMPTY));
        end else begin
          e = shadow_queue.pop_front();
          due_words.push_back(entry_word(e, 5'd0, 1'b1));
        end
      end
      OP_LIST: begin
        hits = 0;
        foreach (shadow_queue[i])
          if (shadow_queue[i].hours > shadow_thr) hits++;
        if (hits == 0) begin
          due_words.push_back(status_word(ST_OK));
        end else begin
          lim = (hits > MAX_RESULTS) ? MAX_RESULTS : hits;
          emitted = 0;
          foreach (shadow_queue[i]) begin
            if (shadow_queue[i].hours > shadow_thr && emitted < lim) begin
              emitted++;
              due_words.push_back(entry_word(shadow_queue[i],
                                  5'((hits > MATCH_SAT) ? MATCH_SAT : hits),
                                  emitted == lim));
            end
          end
        end
      end
      default: begin
        due_words.push_back(status_word(ST_OK));
      end
    endcase
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // compare one delivered word against the oldest one due
  function automatic void check_word(out_word_t act);
    out_word_t exp_w;
    string     bad;
    if (due_words.size() == 0) begin
      note_error($sformatf("unexpected word: %s", show(act)));
      return;
    end
    exp_w = due_words.pop_front();
    bad = "";
    if (act.out_id      !== exp_w.out_id)      bad = {bad, " out_id"};
    if (act.out_hours   !== exp_w.out_hours)   bad = {bad, " out_hours"};
    if (act.out_channel !== exp_w.out_channel) bad = {bad, " out_channel"};
    if (act.entry_valid !== exp_w.entry_valid) bad = {bad, " entry_valid"};
    if (act.status      !== exp_w.status)      bad = {bad, " status"};
    if (act.match_count !== exp_w.match_count) bad = {bad, " match_count"};
    if (act.last        !== exp_w.last)        bad = {bad, " last"};
    if (bad != "")
      note_error($sformatf("word mismatch (%s ) at cycle %0d\n  exp: %s\n  got: %s",
                           bad, cycle_count, show(exp_w), show(act)));
  endfunction

  // --------------------------------------------------------------------------
  // receiver: checks each accepted word, then picks next cycle's stall.
  // A pressure request gives one long hold-off so the block backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word(out_word);
    if (!pressure_req) begin
      hold_done = 1'b0;
    end else if (!hold_done) begin
      hold_cnt = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // sender and config access
  // --------------------------------------------------------------------------

  // offer one word; valid stays up across back-to-back words
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    apply_queue_op(w);
  endtask

  // setup + access, then an idle gap so psel never toggles within a step
  task automatic cfg_access(logic wr, logic [CFG_AW-1:0] addr,
                            logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rd);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_threshold();
    logic [CFG_DW-1:0] rd;
    cfg_access(1'b0, THR_ADDR, '0, rd);
    if (rd[THR_W-1:0] !== shadow_thr)
      note_error($sformatf("threshold readback: exp %h got %h", shadow_thr,
                           rd[THR_W-1:0]));
  endtask

  // block must be idle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // random stimulus
  // --------------------------------------------------------------------------

  // mostly small values (ties) or values right at the threshold edge
  function automatic logic [7:0] pick_hours();
    int h;
    case ($urandom_range(2))
      0: h = $urandom_range(7);
      1: h = $urandom_range(255);
      default: begin
        h = int'(shadow_thr) + int'($urandom_range(2)) - 1;
        if (h < 0) h = 0;
        if (h > 255) h = 255;
      end
    endcase
    return 8'(h);
  endfunction

  function automatic in_word_t rand_word(int ins_pct);
    in_word_t w;
    int       s;
    w.entry_id = 16'($urandom);
    w.entry_hours = pick_hours();
    w.entry_channel = 1'($urandom);
    if ($urandom_range(99) < ins_pct) begin
      w.op = OP_INSERT;
    end else begin
      s = $urandom_range(99);
      w.op = (s < 55) ? OP_EXTRACT : (s < 93) ? OP_LIST : OP_UNUSED;
    end
    return w;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [15:0] id, logic [7:0] hrs,
                                  logic ch, bit fixed = 1'b0, out_word_t res = '0);
    row_t r;
    r.w = '{op: op, entry_id: id, entry_hours: hrs, entry_channel: ch};
    r.fixed = fixed;
    r.res = res;
    plan.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_DW-1:0] dummy;
    int                thr;

    // Directed table, threshold at its reset value 3.
    // Empty queue: extract reports empty, list has no match, op 3 is a no-op.
    add_row(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, 1'b1, status_word(ST_EMPTY));
    add_row(OP_LIST,    16'h0000, 8'h00, 1'b0, 1'b1, status_word(ST_OK));
    add_row(OP_UNUSED,  16'hFFFF, 8'hFF, 1'b1, 1'b1, status_word(ST_OK));
    // field extremes, hours at and just above the threshold, tie at the top
    add_row(OP_INSERT,  16'hFFFF, 8'hFF, 1'b1, 1'b1, status_word(ST_OK));
    add_row(OP_INSERT,  16'h0000, 8'h00, 1'b0, 1'b1, status_word(ST_OK));
    add_row(OP_INSERT,  16'h1234, 8'h03, 1'b0, 1'b1, status_word(ST_OK));
    add_row(OP_INSERT,  16'h0004, 8'h04, 1'b1, 1'b1, status_word(ST_OK));
    add_row(OP_INSERT,  16'hA5A5, 8'hFF, 1'b0, 1'b1, status_word(ST_OK));
    add_row(OP_LIST,    16'h0000, 8'h00, 1'b0);
    // first of the two equal-hours entries leaves first
    add_row(OP_EXTRACT, 16'h0000, 8'h00, 1'b0, 1'b1,
            entry_word('{id: 16'hFFFF, hours: 8'hFF, channel: 1'b1}, 5'd0, 1'b1));
    // fill to capacity, with a second tie on hours 3
    for (int i = 0; i < 12; i++)
      add_row(OP_INSERT, 16'hC000 + 16'(i), 8'(i * 37), 1'(i));
    add_row(OP_INSERT,  16'h5A5A, 8'h80, 1'b1, 1'b1, status_word(ST_FULL));
    add_row(OP_LIST,    16'h0000, 8'h00, 1'b0);
    add_row(OP_EXTRACT, 16'h0000, 8'h00, 1'b0);

    //            thr  idle stall press ins
    phases[0] = '{0,   0,   0,    1'b0, 50};   // no idling
    phases[1] = '{255, 70,  0,    1'b0, 55};   // sender gaps, list never matches
    phases[2] = '{-1,  0,   70,   1'b0, 50};   // receiver stalls
    phases[3] = '{128, 24,  24,   1'b0, 70};   // both, insert-heavy to hit full
    phases[4] = '{-1,  0,   0,    1'b1, 60};   // long output hold-off
    phases[5] = '{3,   0,   0,    1'b0, 35};   // drain, no idling

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_threshold();

    foreach (plan[i]) begin
      send_word(plan[i].w);
      if (plan[i].fixed) due_words[due_words.size() - 1] = plan[i].res;
    end

    foreach (phases[p]) begin
      drain();
      thr = (phases[p].thr < 0) ? int'($urandom_range(255)) : phases[p].thr;
      cfg_access(1'b1, THR_ADDR, CFG_DW'(thr), dummy);
      shadow_thr = THR_W'(thr);
      // a write to an unmapped address must leave the threshold alone
      cfg_access(1'b1, SPARE_ADDR, CFG_DW'($urandom), dummy);
      check_threshold();
      idle_pct = phases[p].idle_pct;
      stall_pct = phases[p].stall_pct;
      pressure_req = phases[p].press;
      repeat (PHASE_WORDS) send_word(rand_word(phases[p].ins_pct));
      pressure_req = 1'b0;
    end

    drain();
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("tb_sorted_priority_queue passed");
    end else begin
      $display("tb_sorted_priority_queue failed");
    end
    $finish;
  end

endmodule
